FILE: hw/rtl/rau_pkg.sv
// Shared types and constants for the rational arithmetic unit.
// Holds beat structs, operation and status codes, sequencer states and widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rau_pkg;

	// operand width of each fraction part
	localparam int OPW = 16;
	// magnitude width of products and sums
	localparam int MW = 2 * OPW;
	// width of the common power-of-two count in the binary gcd
	localparam int KW = $clog2(MW + 1);
	// width of the divider step counter
	localparam int DCW = $clog2(MW);

	localparam int RES_NUM_W = 33;
	localparam int RES_DEN_W = 32;

	typedef enum logic [1:0] {
		FN_ADD,
		FN_SUB,
		FN_MUL,
		FN_DIV
	} func_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_ZERO_DEN,
		ST_UNDEF
	} status_t;

	typedef struct packed {
		func_t                  func;
		logic signed [OPW-1:0]  lhs_num;
		logic signed [OPW-1:0]  lhs_den;
		logic signed [OPW-1:0]  rhs_num;
		logic signed [OPW-1:0]  rhs_den;
	} req_t;

	typedef struct packed {
		logic signed [RES_NUM_W-1:0] res_num;
		logic [RES_DEN_W-1:0]        res_den;
		status_t                     status;
	} rsp_t;

	typedef enum logic [2:0] {
		SQ_IDLE,
		SQ_MUL0,
		SQ_MUL1,
		SQ_MUL2,
		SQ_SUM,
		SQ_RED,
		SQ_OUT
	} seq_state_t;

	typedef enum logic [1:0] {
		RD_IDLE,
		RD_GCD,
		RD_DIV
	} red_state_t;

	// request into the reduction engine
	typedef struct packed {
		logic          start;
		logic [MW-1:0] num;
		logic [MW-1:0] den;
	} red_req_t;

	// result of the reduction engine, held until the next start
	typedef struct packed {
		logic          done;
		logic          g_zero;
		logic [MW-1:0] qn;
		logic [MW-1:0] qd;
	} red_rsp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rau_reduce.sv
// Reduction engine: binary gcd of two magnitudes, then both divided by it.
// One shift or subtract step per cycle for the gcd, restoring division after.
// Depends on rau_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rau_reduce (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire rau_pkg::red_req_t req,
	output rau_pkg::red_rsp_t     rsp
);

	rau_pkg::red_state_t state_q, state_d;

	logic [rau_pkg::MW-1:0]  a_q, b_q, g_q;
	logic [rau_pkg::KW-1:0]  k_q;
	logic [rau_pkg::MW-1:0]  xn_q, xd_q, remn_q, remd_q;
	logic [rau_pkg::DCW-1:0] cnt_q;

	logic                    gcd_end;
	logic [rau_pkg::MW-1:0]  gcd_val;
	logic                    a_ge;
	logic [rau_pkg::MW-1:0]  dif;
	logic                    done;

	logic [rau_pkg::MW:0]    rn2, rd2, gx;
	logic                    geq_n, geq_d;

	assign gcd_end = (a_q == '0) || (b_q == '0);
	assign gcd_val = (a_q | b_q) << k_q;
	assign a_ge    = a_q >= b_q;
	assign dif     = a_ge ? (a_q - b_q) : (b_q - a_q);

	assign gx    = {1'b0, g_q};
	assign rn2   = {remn_q, xn_q[rau_pkg::MW-1]};
	assign rd2   = {remd_q, xd_q[rau_pkg::MW-1]};
	assign geq_n = rn2 >= gx;
	assign geq_d = rd2 >= gx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rau_pkg::RD_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		done    = 1'b0;
		case (state_q)
			rau_pkg::RD_IDLE: begin
				if (req.start) begin
					state_d = rau_pkg::RD_GCD;
				end
			end
			rau_pkg::RD_GCD: begin
				if (gcd_end) begin
					if (gcd_val == '0) begin
						state_d = rau_pkg::RD_IDLE;
						done    = 1'b1;
					end else begin
						state_d = rau_pkg::RD_DIV;
					end
				end
			end
			rau_pkg::RD_DIV: begin
				if (cnt_q == '0) begin
					state_d = rau_pkg::RD_IDLE;
					done    = 1'b1;
				end
			end
			default: begin
				state_d = rau_pkg::RD_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			rau_pkg::RD_IDLE: begin
				if (req.start) begin
					a_q  <= req.num;
					b_q  <= req.den;
					xn_q <= req.num;
					xd_q <= req.den;
					k_q  <= '0;
				end
			end
			rau_pkg::RD_GCD: begin
				if (gcd_end) begin
					g_q    <= gcd_val;
					remn_q <= '0;
					remd_q <= '0;
					cnt_q  <= rau_pkg::DCW'(rau_pkg::MW - 1);
				end else if (!a_q[0] && !b_q[0]) begin
					// common factor of two: pull it out and count it
					a_q <= a_q >> 1;
					b_q <= b_q >> 1;
					k_q <= k_q + 1'b1;
				end else if (!a_q[0]) begin
					a_q <= a_q >> 1;
				end else if (!b_q[0]) begin
					b_q <= b_q >> 1;
				end else if (a_ge) begin
					a_q <= dif >> 1;
				end else begin
					b_q <= dif >> 1;
				end
			end
			rau_pkg::RD_DIV: begin
				remn_q <= geq_n ? rau_pkg::MW'(rn2 - gx) : rn2[rau_pkg::MW-1:0];
				remd_q <= geq_d ? rau_pkg::MW'(rd2 - gx) : rd2[rau_pkg::MW-1:0];
				xn_q   <= {xn_q[rau_pkg::MW-2:0], geq_n};
				xd_q   <= {xd_q[rau_pkg::MW-2:0], geq_d};
				cnt_q  <= cnt_q - 1'b1;
			end
			default: begin
				g_q <= g_q;
			end
		endcase
	end

	assign rsp.done   = done;
	assign rsp.g_zero = (g_q == '0);
	assign rsp.qn     = (g_q == '0) ? '0 : xn_q;
	assign rsp.qd     = (g_q == '0) ? '0 : xd_q;

endmodule

`default_nettype wire

FILE: hw/rtl/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit: sequencer, shared multiplier,
// sign handling and output register. Depends on rau_pkg and rau_reduce.
//
// Usage:
//   Request channel (req_valid, req_stall, req): one beat carries an
//   operation code (add, subtract, multiply, divide) and two signed
//   fractions. Response channel (rsp_valid, rsp_stall, rsp): one beat per
//   request with the reduced numerator, a non-negative denominator and a
//   status (ok, zero denominator, zero over zero).
//   One request is in work at a time; req_stall is high from the cycle
//   after acceptance until the result has been moved to the output
//   register. A finished result waits in that register while the next
//   request is already taken and worked on.
//   Work from accept to rsp_valid: three products on the shared 16x16
//   multiplier (MUL0, MUL1, MUL2), a sign/sum step, the binary gcd steps
//   (one compare-subtract or shift per cycle), 32 restoring divide steps
//   and an output load step. Zero over zero skips the divide. A new
//   request is taken only after the last result has been loaded; the gcd
//   loop is the part of the work whose length varies.
//   Reset (arst_n low) clears the sequencer and drops any pending result.
//   While rsp_stall is high the result holds; the block finishes the next
//   request and then waits until the output register frees up.
`timescale 1ns / 1ps
`default_nettype none

module rational_arithmetic_unit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire rau_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output rau_pkg::rsp_t      rsp
);

	localparam int OPW = rau_pkg::OPW;
	localparam int MW  = rau_pkg::MW;

	rau_pkg::seq_state_t state_q, state_d;

	// captured operands: magnitudes and signs after subtract / divide fixup
	rau_pkg::func_t op_q;
	logic [OPW-1:0] ln_mag_q, ld_mag_q, rn_mag_q, rd_mag_q;
	logic           ln_neg_q, ld_neg_q, rn_neg_q, rd_neg_q;

	logic [OPW-1:0] ln_mag, ld_mag, rn_mag, rd_mag;
	logic           rn_neg_adj;

	// shared multiplier and product registers
	logic [OPW-1:0] ma, mb;
	logic [MW-1:0]  prod;
	logic [MW-1:0]  p0_q, p1_q, p2_q;

	logic           is_add;
	logic           s0e, s1e;
	logic [MW-1:0]  sum;
	logic           sneg;
	logic           neg_d, neg_q;

	logic           accept;
	logic           load_out;

	rau_pkg::red_req_t red_req;
	rau_pkg::red_rsp_t red_rsp;

	rau_pkg::rsp_t                      rsp_d, rsp_q;
	logic                               rsp_valid_q;
	logic [rau_pkg::RES_NUM_W-1:0]      qn_ext;

	assign accept = req_valid && !req_stall;
	assign is_add = (op_q == rau_pkg::FN_ADD) || (op_q == rau_pkg::FN_SUB);

	// magnitudes of the raw operands; the most negative value maps to 2^(OPW-1)
	assign ln_mag = req.lhs_num[OPW-1] ? OPW'(-req.lhs_num) : OPW'(req.lhs_num);
	assign ld_mag = req.lhs_den[OPW-1] ? OPW'(-req.lhs_den) : OPW'(req.lhs_den);
	assign rn_mag = req.rhs_num[OPW-1] ? OPW'(-req.rhs_num) : OPW'(req.rhs_num);
	assign rd_mag = req.rhs_den[OPW-1] ? OPW'(-req.rhs_den) : OPW'(req.rhs_den);

	// subtract flips the right numerator's sign, but only when it is nonzero
	assign rn_neg_adj = req.rhs_num[OPW-1] ^
		((req.func == rau_pkg::FN_SUB) && (rn_mag != '0));

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= req.func;
			ln_mag_q <= ln_mag;
			ln_neg_q <= req.lhs_num[OPW-1];
			ld_mag_q <= ld_mag;
			ld_neg_q <= req.lhs_den[OPW-1];
			if (req.func == rau_pkg::FN_DIV) begin
				// divide: swap the right operand's parts, then multiply
				rn_mag_q <= rd_mag;
				rn_neg_q <= req.rhs_den[OPW-1];
				rd_mag_q <= rn_mag;
				rd_neg_q <= rn_neg_adj;
			end else begin
				rn_mag_q <= rn_mag;
				rn_neg_q <= rn_neg_adj;
				rd_mag_q <= rd_mag;
				rd_neg_q <= req.rhs_den[OPW-1];
			end
		end
	end

	// one multiplier, three uses: ln*rd, then ld*rn (or ln*rn), then ld*rd
	always_comb begin
		case (state_q)
			rau_pkg::SQ_MUL0: begin
				ma = ln_mag_q;
				mb = rd_mag_q;
			end
			rau_pkg::SQ_MUL1: begin
				ma = is_add ? ld_mag_q : ln_mag_q;
				mb = rn_mag_q;
			end
			default: begin
				ma = ld_mag_q;
				mb = rd_mag_q;
			end
		endcase
		prod = {{OPW{1'b0}}, ma} * {{OPW{1'b0}}, mb};
	end

	always_ff @(posedge clk) begin
		if (state_q == rau_pkg::SQ_MUL0) begin
			p0_q <= prod;
		end
		if (state_q == rau_pkg::SQ_MUL1) begin
			p1_q <= prod;
		end
		if (state_q == rau_pkg::SQ_MUL2) begin
			p2_q <= prod;
		end
	end

	// sign-magnitude sum of the two cross products; zero carries no sign
	always_comb begin
		s0e = (ln_neg_q ^ rd_neg_q) && (p0_q != '0);
		s1e = (is_add ? (ld_neg_q ^ rn_neg_q) : (ln_neg_q ^ rn_neg_q)) && (p1_q != '0);
		if (!is_add) begin
			sum  = p1_q;
			sneg = s1e;
		end else if (s0e == s1e) begin
			sum  = p0_q + p1_q;
			sneg = s0e;
		end else if (p0_q >= p1_q) begin
			sum  = p0_q - p1_q;
			sneg = s0e;
		end else begin
			sum  = p1_q - p0_q;
			sneg = s1e;
		end
		// fold a negative denominator into the numerator's sign
		neg_d = (sneg && (sum != '0)) ^ ((ld_neg_q ^ rd_neg_q) && (p2_q != '0));
	end

	always_ff @(posedge clk) begin
		if (state_q == rau_pkg::SQ_SUM) begin
			neg_q <= neg_d;
		end
	end

	assign red_req.start = (state_q == rau_pkg::SQ_SUM);
	assign red_req.num   = sum;
	assign red_req.den   = p2_q;

	rau_reduce u_reduce (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (red_req),
		.rsp    (red_rsp)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rau_pkg::SQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		load_out  = 1'b0;
		case (state_q)
			rau_pkg::SQ_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					state_d = rau_pkg::SQ_MUL0;
				end
			end
			rau_pkg::SQ_MUL0: state_d = rau_pkg::SQ_MUL1;
			rau_pkg::SQ_MUL1: state_d = rau_pkg::SQ_MUL2;
			rau_pkg::SQ_MUL2: state_d = rau_pkg::SQ_SUM;
			rau_pkg::SQ_SUM:  state_d = rau_pkg::SQ_RED;
			rau_pkg::SQ_RED: begin
				if (red_rsp.done) begin
					state_d = rau_pkg::SQ_OUT;
				end
			end
			rau_pkg::SQ_OUT: begin
				// hold until the output register is free or being drained
				if (!rsp_valid_q || !rsp_stall) begin
					load_out = 1'b1;
					state_d  = rau_pkg::SQ_IDLE;
				end
			end
			default: begin
				state_d = rau_pkg::SQ_IDLE;
			end
		endcase
	end

	// result formatting
	always_comb begin
		qn_ext        = rau_pkg::RES_NUM_W'(red_rsp.qn);
		rsp_d.res_num = neg_q ? -qn_ext : qn_ext;
		rsp_d.res_den = rau_pkg::RES_DEN_W'(red_rsp.qd);
		if (red_rsp.g_zero) begin
			rsp_d.status = rau_pkg::ST_UNDEF;
		end else if (red_rsp.qd == '0) begin
			rsp_d.status = rau_pkg::ST_ZERO_DEN;
		end else begin
			rsp_d.status = rau_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef NO_ASSERTIONS
	// one request at a time: after an accepted beat the input stalls
	a_accept_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> req_stall)
		else $error("request accepted while a previous one is in work");

	// the reduction engine is started only from the sum step
	a_start_from_sum: assert property (@(posedge clk) disable iff (!arst_n)
		red_req.start |-> $past(state_q) == rau_pkg::SQ_MUL2)
		else $error("reduction started out of sequence");

	// zero over zero always comes out as 0/0
	a_undef_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == rau_pkg::ST_UNDEF) |->
		(rsp.res_num == '0 && rsp.res_den == '0))
		else $error("undefined result is not 0/0");

	// an ok result never has a zero denominator
	a_ok_den: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == rau_pkg::ST_OK) |-> rsp.res_den != '0)
		else $error("ok status with zero denominator");
`endif

endmodule

`default_nettype wire

FILE: tb/rau_checker.sv
`timescale 1ns / 1ps
// Checker for the rational arithmetic unit: watches the request and response
// channels, predicts each reduced fraction and compares it field by field.
// Depends on rau_pkg.
module rau_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_stall,
	input  rau_pkg::req_t req,
	input  logic          rsp_valid,
	input  logic          rsp_stall,
	input  rau_pkg::rsp_t rsp,
	output int            fault_count,
	output int            owed_results
);
	import rau_pkg::*;

	// keep the log short when the block is badly broken
	localparam int PRINT_CAP = 40;

	typedef struct {
		bit              neg;
		longint unsigned mag;
	} smag_t;

	typedef struct {
		req_t cause;
		rsp_t want;
	} owed_t;

	owed_t owed_fractions[$];

	function automatic smag_t split_sign(logic signed [OPW-1:0] v);
		longint s;
		smag_t r;
		s = v;
		r.neg = s < 0;
		r.mag = r.neg ? -s : s;
		return r;
	endfunction

	function automatic smag_t smag_times(smag_t a, smag_t b);
		smag_t r;
		r.mag = a.mag * b.mag;
		r.neg = (r.mag != 0) && (a.neg != b.neg);
		return r;
	endfunction

	function automatic smag_t smag_plus(smag_t a, smag_t b);
		smag_t r;
		if (a.neg == b.neg) begin
			r.mag = a.mag + b.mag;
			r.neg = a.neg;
		end else if (a.mag >= b.mag) begin
			r.mag = a.mag - b.mag;
			r.neg = a.neg;
		end else begin
			r.mag = b.mag - a.mag;
			r.neg = b.neg;
		end
		if (r.mag == 0)
			r.neg = 1'b0;
		return r;
	endfunction

	function automatic longint unsigned euclid_gcd(longint unsigned a, longint unsigned b);
		longint unsigned t;
		while (b != 0) begin
			t = a % b;
			a = b;
			b = t;
		end
		return a;
	endfunction

	function automatic rsp_t reduced_fraction(req_t r);
		smag_t ln, ld, rn, rd, num, den, tmp;
		longint unsigned g, qn, qd;
		bit neg;
		rsp_t f;
		ln = split_sign(r.lhs_num);
		ld = split_sign(r.lhs_den);
		rn = split_sign(r.rhs_num);
		rd = split_sign(r.rhs_den);
		if (r.func == FN_SUB && rn.mag != 0)
			rn.neg = !rn.neg;
		// divide multiplies by the reciprocal
		if (r.func == FN_DIV) begin
			tmp = rn;
			rn = rd;
			rd = tmp;
		end
		if (r.func == FN_ADD || r.func == FN_SUB)
			num = smag_plus(smag_times(ln, rd), smag_times(ld, rn));
		else
			num = smag_times(ln, rn);
		den = smag_times(ld, rd);
		// move a negative denominator's sign onto the numerator
		neg = num.neg ^ (den.mag != 0 && den.neg);
		g = euclid_gcd(num.mag, den.mag);
		if (g == 0) begin
			f.res_num = '0;
			f.res_den = '0;
			f.status = ST_UNDEF;
		end else begin
			qn = num.mag / g;
			qd = den.mag / g;
			f.res_num = RES_NUM_W'(neg ? -qn : qn);
			f.res_den = RES_DEN_W'(qd);
			f.status = (qd == 0) ? ST_ZERO_DEN : ST_OK;
		end
		return f;
	endfunction

	function automatic string describe(req_t c);
		return $sformatf("%s %0d/%0d, %0d/%0d", c.func.name(), c.lhs_num, c.lhs_den,
			c.rhs_num, c.rhs_den);
	endfunction

	task automatic report_fault(string what);
		if (fault_count < PRINT_CAP)
			$display("%0t ns checker: %s", $time, what);
		fault_count++;
	endtask

	always @(posedge clk) begin
		owed_t exp;
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				exp.cause = req;
				exp.want = reduced_fraction(req);
				owed_fractions.push_back(exp);
			end
			if (rsp_valid && !rsp_stall) begin
				if (owed_fractions.size() == 0) begin
					report_fault($sformatf("response beat %0d/%0d with nothing owed",
						rsp.res_num, rsp.res_den));
				end else begin
					exp = owed_fractions.pop_front();
					if (rsp.res_num !== exp.want.res_num)
						report_fault($sformatf("res_num %0d, want %0d for %s",
							rsp.res_num, exp.want.res_num, describe(exp.cause)));
					if (rsp.res_den !== exp.want.res_den)
						report_fault($sformatf("res_den %0d, want %0d for %s",
							rsp.res_den, exp.want.res_den, describe(exp.cause)));
					if (rsp.status !== exp.want.status)
						report_fault($sformatf("status %0d, want %0d for %s",
							rsp.status, exp.want.status, describe(exp.cause)));
				end
			end
		end
		owed_results <= owed_fractions.size();
	end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the rational arithmetic unit: clock, reset, request and
// response stall stimulus, and the verdict. Depends on rau_pkg,
// rational_arithmetic_unit and rau_checker.
module tb_top;
	import rau_pkg::*;

	localparam int RANDOM_ITEMS = 1100;
	// pause the sender until the block is empty every so many beats
	localparam int DRAIN_EVERY = 250;
	// the limit covers the worst-case work, idle gap and response stall of
	// every beat, several times over the run
	localparam int CYCLE_LIMIT = 2_500_000;
	// longer than the slowest gcd and divide pass
	localparam int SETTLE_CYCLES = 150;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req_beat;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp_beat;

	int fault_count;
	int owed_results;
	int cycle_count;

	always #1 clk = ~clk;

	rational_arithmetic_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req_beat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp_beat)
	);

	rau_checker watch (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.req          (req_beat),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.rsp          (rsp_beat),
		.fault_count  (fault_count),
		.owed_results (owed_results)
	);

	// Drop the run if the block hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Gap lengths: mostly none or short, now and then long enough to span a
	// whole reduction so idle time lands on every phase of the work.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 8);
		else if (r < 97)
			return $urandom_range(9, 60);
		return $urandom_range(61, 200);
	endfunction

	// Operand values: raw bits, small values around zero, the extremes, and
	// products with a shared factor so the gcd has real work to do.
	function automatic logic signed [OPW-1:0] random_operand();
		int r;
		int v;
		r = $urandom_range(0, 99);
		if (r < 35) begin
			v = $urandom;
		end else if (r < 65) begin
			v = $urandom_range(0, 40);
			v = v - 20;
		end else if (r < 75) begin
			case ($urandom_range(0, 5))
				0: v = -(1 << (OPW - 1));
				1: v = -(1 << (OPW - 1)) + 1;
				2: v = -1;
				3: v = 0;
				4: v = 1;
				default: v = (1 << (OPW - 1)) - 1;
			endcase
		end else begin
			v = $urandom_range(0, 360);
			v = (v - 180) * int'($urandom_range(1, 180));
		end
		return OPW'(v);
	endfunction

	function automatic req_t random_request();
		req_t b;
		b.func = func_t'($urandom_range(0, 3));
		b.lhs_num = random_operand();
		b.lhs_den = random_operand();
		b.rhs_num = random_operand();
		b.rhs_den = random_operand();
		return b;
	endfunction

	// Present one beat and hold it until the block takes it. A following
	// beat may keep valid high with no gap.
	task automatic issue_request(req_t beat);
		req_beat <= beat;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	// Drop valid for a random gap, or keep streaming when the gap is zero.
	task automatic idle_gap();
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold off the sender until every owed result has come back.
	task automatic drain_results();
		req_valid <= 1'b0;
		@(posedge clk);
		while (owed_results != 0)
			@(posedge clk);
	endtask

	task automatic issue_op(func_t f, int ln, int ld, int rn, int rd);
		req_t b;
		b.func = f;
		b.lhs_num = OPW'(ln);
		b.lhs_den = OPW'(ld);
		b.rhs_num = OPW'(rn);
		b.rhs_den = OPW'(rd);
		issue_request(b);
		idle_gap();
	endtask

	// Response side: alternate free runs and stalls. Neither run is ever
	// empty, so stall changes at most once per edge; the long free runs
	// give stretches with no back-pressure at all.
	initial begin
		int free_run;
		int hold;
		rsp_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			free_run = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 800)
				: $urandom_range(1, 12);
			hold = 1 + pick_gap();
			repeat (free_run) @(posedge clk);
			rsp_stall <= 1'b1;
			repeat (hold) @(posedge clk);
			rsp_stall <= 1'b0;
		end
	end

	initial begin
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req_beat <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed beats: every operation, the operand extremes, zero
		// denominators, zero over zero, zero numerators, negative denominators.
		issue_op(FN_ADD, 1, 2, 1, 3);
		issue_op(FN_SUB, 1, 2, 1, 2);
		issue_op(FN_MUL, -32768, -32768, -32768, -32768);
		issue_op(FN_DIV, 32767, -32768, -32768, 32767);
		issue_op(FN_ADD, -32768, 32767, -32768, 32767);
		issue_op(FN_SUB, 32767, 1, -32768, 1);
		issue_op(FN_MUL, 0, 5, 3, 7);
		issue_op(FN_ADD, 1, 0, 1, 1);
		issue_op(FN_SUB, -3, 0, 2, 5);
		issue_op(FN_MUL, 0, 0, 4, 4);
		issue_op(FN_DIV, 5, 3, 0, 7);
		issue_op(FN_DIV, 0, 3, 0, 7);
		issue_op(FN_ADD, 0, 0, 0, 0);
		issue_op(FN_MUL, -1, -1, -1, -1);
		issue_op(FN_ADD, 32767, 32767, -32768, -32768);
		issue_op(FN_DIV, -32768, 1, -1, 1);
		issue_op(FN_ADD, 7, -3, 2, -5);
		issue_op(FN_MUL, 12, -18, -9, 6);
		issue_op(FN_SUB, 0, -4, 0, 9);
		issue_op(FN_DIV, 1, 1, -32768, -32768);
		issue_op(FN_MUL, 32767, 1, 32767, 1);
		issue_op(FN_ADD, 1, 32767, 1, 32766);
		drain_results();

		// Random beats, with the sender pausing for an empty block now and then.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			issue_request(random_request());
			if (i % DRAIN_EVERY == DRAIN_EVERY - 1)
				drain_results();
			else
				idle_gap();
		end
		drain_results();

		// Leave room for a stray beat to show up before the verdict.
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fault_count == 0 && owed_results == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
